// ----- hdl/pnq_pkg.sv -----
// ----------------------------------------------------------------------------
// pnq_pkg: shared types and constants of the point store
// Store depth, derived widths, opcodes and the command and status groups
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pnq_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int COORD_W    = 16;
  localparam int SCALE_W    = 8;
  localparam int WGT_W      = 2 * SCALE_W;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int WSQ_W      = SQ_W + WGT_W;
  localparam int DIST_W     = WSQ_W + 1;
  localparam int OUT_DIST_W = 51;
  localparam int OUT_IDX_W  = 10;
  localparam int OUT_CNT_W  = 11;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_POP     = 2'd1,
    OP_CLOSEST = 2'd2,
    OP_EXTENTS = 2'd3
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted beat and arm the scan
    logic issue;   // read the next stored point
    logic finish;  // update the store state and present the result
  } pnq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic count_zero;
    logic last_issue;
    logic pipe_busy;
  } pnq_stat_t;

endpackage

// ----- hdl/pnq_ram.sv -----
// ----------------------------------------------------------------------------
// pnq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pnq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/pnq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pnq_ctrl: sequencing state machine
// Accepts a beat, walks the stored points when the opcode is a query and the
// store holds points, drains the datapath pipeline and finishes the item.
// ----------------------------------------------------------------------------
module pnq_ctrl import pnq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pnq_stat_t stat,
  output pnq_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat.is_query && !stat.count_zero) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/pnq_dp.sv -----
// ----------------------------------------------------------------------------
// pnq_dp: point store datapath
// Holds the circular store and its pointers, the scan pipeline for the
// closest and extents queries, and the result registers.
// ----------------------------------------------------------------------------
module pnq_dp import pnq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pnq_cmd_t                     cmd,
  output pnq_stat_t                    stat,
  input  logic [1:0]                   in_opcode,
  input  logic signed [COORD_W-1:0]    in_coord_x,
  input  logic signed [COORD_W-1:0]    in_coord_y,
  input  logic [SCALE_W-1:0]           in_scale_x,
  input  logic [SCALE_W-1:0]           in_scale_y,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [OUT_IDX_W-1:0]         out_best_index,
  output logic signed [COORD_W-1:0]    out_best_x,
  output logic signed [COORD_W-1:0]    out_best_y,
  output logic [OUT_DIST_W-1:0]        out_best_distance,
  output logic signed [COORD_W-1:0]    out_min_x,
  output logic signed [COORD_W-1:0]    out_max_x,
  output logic signed [COORD_W-1:0]    out_min_y,
  output logic signed [COORD_W-1:0]    out_max_y,
  output logic [OUT_CNT_W-1:0]         out_point_count,
  output logic                         out_overflow
);

  // Store state.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] oldest_r, oldest_nxt;

  // Captured beat.
  opcode_t                   q_op_r;
  logic signed [COORD_W-1:0] q_cx_r, q_cy_r;
  logic [WGT_W-1:0]          wx_r, wy_r;

  // Scan address side.
  logic [ADDR_W-1:0] pos_r, slot_r;

  // Pipeline stages.
  logic                      rd_v_r;
  logic [ADDR_W-1:0]         rd_pos_r;
  logic [COORD_W-1:0]        rx, ry;
  logic                      s1_v_r, s2_v_r, s3_v_r;
  logic [ADDR_W-1:0]         s1_pos_r, s2_pos_r, s3_pos_r;
  logic [COORD_W-1:0]        s1_x_r, s1_y_r, s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic [COORD_W-1:0]        s1_dx_r, s1_dy_r;
  logic [SQ_W-1:0]           s2_sx_r, s2_sy_r;
  logic [WSQ_W-1:0]          s3_wx_r, s3_wy_r;

  logic signed [COORD_W:0]   dx, dy, dxa, dya;
  logic [DIST_W-1:0]         cand_d;

  // Running results.
  logic                      have_r;
  logic [DIST_W-1:0]         best_d_r;
  logic [ADDR_W-1:0]         best_pos_r;
  logic [COORD_W-1:0]        best_x_r, best_y_r;
  logic signed [COORD_W-1:0] mn_x_r, mx_x_r, mn_y_r, mx_y_r;

  // Append slot and pop wrap.
  logic              full, empty, app_ok, pop_ok;
  logic [ADDR_W:0]   app_sum;
  logic [ADDR_W-1:0] app_slot;

  // Result registers.
  logic                      out_valid_r, out_found_r, out_overflow_r;
  logic [OUT_IDX_W-1:0]      out_idx_r;
  logic [COORD_W-1:0]        out_bx_r, out_by_r;
  logic [OUT_DIST_W-1:0]     out_dist_r;
  logic signed [COORD_W-1:0] out_mnx_r, out_mxx_r, out_mny_r, out_mxy_r;
  logic [OUT_CNT_W-1:0]      out_cnt_r;

  assign full    = (count_r == CNT_W'(STORE_DEPTH));
  assign empty   = (count_r == '0);
  assign app_ok  = cmd.finish && (q_op_r == OP_APPEND) && !full;
  assign pop_ok  = cmd.finish && (q_op_r == OP_POP) && !empty;

  assign app_sum  = {1'b0, oldest_r} + {1'b0, count_r[ADDR_W-1:0]};
  assign app_slot = (app_sum >= (ADDR_W+1)'(STORE_DEPTH)) ?
                    ADDR_W'(app_sum - (ADDR_W+1)'(STORE_DEPTH)) : app_sum[ADDR_W-1:0];

  always_comb begin
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    if (app_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt  = count_r - 1'b1;
      oldest_nxt = (oldest_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      oldest_r <= '0;
    end else begin
      count_r  <= count_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  pnq_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_ram_x (
    .clk     (clk),
    .wr_en   (app_ok),
    .wr_addr (app_slot),
    .wr_data (q_cx_r),
    .rd_en   (cmd.issue),
    .rd_addr (slot_r),
    .rd_data (rx)
  );

  pnq_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_ram_y (
    .clk     (clk),
    .wr_en   (app_ok),
    .wr_addr (app_slot),
    .wr_data (q_cy_r),
    .rd_en   (cmd.issue),
    .rd_addr (slot_r),
    .rd_data (ry)
  );

  // Capture and scan address generation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_op_r <= opcode_t'(in_opcode);
      q_cx_r <= in_coord_x;
      q_cy_r <= in_coord_y;
      wx_r   <= in_scale_x * in_scale_x;
      wy_r   <= in_scale_y * in_scale_y;
      pos_r  <= '0;
      slot_r <= oldest_r;
    end else if (cmd.issue) begin
      pos_r  <= pos_r + 1'b1;
      slot_r <= (slot_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  // Stage valids are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.issue;
      s1_v_r <= rd_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign dx  = {q_cx_r[COORD_W-1], q_cx_r} - {rx[COORD_W-1], rx};
  assign dy  = {q_cy_r[COORD_W-1], q_cy_r} - {ry[COORD_W-1], ry};
  assign dxa = dx[COORD_W] ? -dx : dx;
  assign dya = dy[COORD_W] ? -dy : dy;

  // Absolute difference, square, weight: at most one multiplier level per stage.
  always_ff @(posedge clk) begin
    rd_pos_r <= pos_r;
    s1_pos_r <= rd_pos_r;
    s1_x_r   <= rx;
    s1_y_r   <= ry;
    s1_dx_r  <= dxa[COORD_W-1:0];
    s1_dy_r  <= dya[COORD_W-1:0];
    s2_pos_r <= s1_pos_r;
    s2_x_r   <= s1_x_r;
    s2_y_r   <= s1_y_r;
    s2_sx_r  <= s1_dx_r * s1_dx_r;
    s2_sy_r  <= s1_dy_r * s1_dy_r;
    s3_pos_r <= s2_pos_r;
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    s3_wx_r  <= s2_sx_r * wx_r;
    s3_wy_r  <= s2_sy_r * wy_r;
  end

  assign cand_d = {1'b0, s3_wx_r} + {1'b0, s3_wy_r};

  // Running minimum and extents. The walk is oldest first, so a strict
  // compare keeps the oldest of equal distances.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      have_r     <= 1'b0;
      best_d_r   <= '0;
      best_pos_r <= '0;
      best_x_r   <= '0;
      best_y_r   <= '0;
      mn_x_r     <= COORD_MAX;
      mx_x_r     <= COORD_MIN;
      mn_y_r     <= COORD_MAX;
      mx_y_r     <= COORD_MIN;
    end else begin
      if (s3_v_r && (!have_r || cand_d < best_d_r)) begin
        have_r     <= 1'b1;
        best_d_r   <= cand_d;
        best_pos_r <= s3_pos_r;
        best_x_r   <= s3_x_r;
        best_y_r   <= s3_y_r;
      end
      if (rd_v_r) begin
        if ($signed(rx) < mn_x_r) mn_x_r <= $signed(rx);
        if ($signed(rx) > mx_x_r) mx_x_r <= $signed(rx);
        if ($signed(ry) < mn_y_r) mn_y_r <= $signed(ry);
        if ($signed(ry) > mx_y_r) mx_y_r <= $signed(ry);
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r    <= 1'b0;
      out_idx_r      <= '0;
      out_bx_r       <= '0;
      out_by_r       <= '0;
      out_dist_r     <= '0;
      out_mnx_r      <= '0;
      out_mxx_r      <= '0;
      out_mny_r      <= '0;
      out_mxy_r      <= '0;
      out_overflow_r <= (q_op_r == OP_APPEND) && full;
      out_cnt_r      <= OUT_CNT_W'(count_nxt);
      if (q_op_r == OP_CLOSEST && have_r) begin
        out_found_r <= 1'b1;
        out_idx_r   <= OUT_IDX_W'(best_pos_r);
        out_bx_r    <= best_x_r;
        out_by_r    <= best_y_r;
        out_dist_r  <= OUT_DIST_W'(best_d_r);
      end
      if (q_op_r == OP_EXTENTS) begin
        out_mnx_r <= mn_x_r;
        out_mxx_r <= mx_x_r;
        out_mny_r <= mn_y_r;
        out_mxy_r <= mx_y_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_best_index    = out_idx_r;
  assign out_best_x        = out_bx_r;
  assign out_best_y        = out_by_r;
  assign out_best_distance = out_dist_r;
  assign out_min_x         = out_mnx_r;
  assign out_max_x         = out_mxx_r;
  assign out_min_y         = out_mny_r;
  assign out_max_y         = out_mxy_r;
  assign out_point_count   = out_cnt_r;
  assign out_overflow      = out_overflow_r;

  assign stat.is_query   = (q_op_r == OP_CLOSEST) || (q_op_r == OP_EXTENTS);
  assign stat.count_zero = empty;
  assign stat.last_issue = (pos_r == ADDR_W'(count_r - 1'b1));
  assign stat.pipe_busy  = rd_v_r || s1_v_r || s2_v_r || s3_v_r;

endmodule

// ----- hdl/point_store_nearest_query.sv -----
// ----------------------------------------------------------------------------
// point_store_nearest_query: ordered 2-D point store with nearest and
// extents queries
// Top level: joins the sequencing state machine and the store datapath.
// ----------------------------------------------------------------------------
// A beat is taken when start is high while busy is low, and every beat gives
// exactly one result, shown for one cycle with out_valid high; the receiver
// cannot hold it off, so capture it in that cycle. A closest or extents
// query walks every stored point once through a single read port of the
// point memories, one point per cycle, followed by a distance pipeline
// of read, absolute difference, square and weight registers; a query on
// an empty store skips the walk. Busy drops in the cycle the result is
// shown, so the next beat may be started in that same cycle. Coordinates
// are signed Q8.8, weights are unsigned Q4.4 with 16 meaning one, and
// best_distance is the exact sum dx*dx*sx*sx + dy*dy*sy*sy in raw counts.
// The point memories are not cleared after reset; only stored points are
// ever read.
module point_store_nearest_query import pnq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic [SCALE_W-1:0]        in_scale_x,
  input  logic [SCALE_W-1:0]        in_scale_y,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [OUT_IDX_W-1:0]      out_best_index,
  output logic signed [COORD_W-1:0] out_best_x,
  output logic signed [COORD_W-1:0] out_best_y,
  output logic [OUT_DIST_W-1:0]     out_best_distance,
  output logic signed [COORD_W-1:0] out_min_x,
  output logic signed [COORD_W-1:0] out_max_x,
  output logic signed [COORD_W-1:0] out_min_y,
  output logic signed [COORD_W-1:0] out_max_y,
  output logic [OUT_CNT_W-1:0]      out_point_count,
  output logic                      out_overflow
);

  pnq_cmd_t  cmd;
  pnq_stat_t stat;

  // The controller decides when to capture, scan and finish a beat.
  pnq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the store, walks it and forms the result.
  pnq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_scale_x        (in_scale_x),
    .in_scale_y        (in_scale_y),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_best_index    (out_best_index),
    .out_best_x        (out_best_x),
    .out_best_y        (out_best_y),
    .out_best_distance (out_best_distance),
    .out_min_x         (out_min_x),
    .out_max_x         (out_max_x),
    .out_min_y         (out_min_y),
    .out_max_y         (out_max_y),
    .out_point_count   (out_point_count),
    .out_overflow      (out_overflow)
  );

  // While idle, no read of the store may still be in flight.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !stat.pipe_busy)
    else $error("scan pipeline active while idle");

  // The store is never read when it holds no points.
  a_no_scan_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !stat.count_zero)
    else $error("scan issued on an empty store");

  // Each beat gives one result, never two in a row.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results on consecutive cycles");

  // A dropped append only happens on a full store.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_point_count == OUT_CNT_W'(STORE_DEPTH)))
    else $error("overflow reported on a store that is not full");

endmodule
